// File: hdl/eprpm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eprpm_pkg - shared types and constants for the encoder period RPM estimator
// Event codes, register indexes, sequencer states and helper arithmetic.
// ---------------------------------------------------------------------------
package eprpm_pkg;

    localparam int unsigned MEDIAN_ENABLE    = 1;
    localparam int unsigned TIMEOUT_PERIODS  = 3;
    localparam int unsigned MIN_TIMEOUT_US   = 20000;
    localparam int unsigned STALL_TIMEOUT_US = 500000;

    localparam logic [63:0] RPM_NUM_Q4 = 64'd960000000;
    localparam logic [47:0] US_PER_S   = 48'd1000000;
    localparam logic [63:0] US_HALF    = 64'd500000;
    localparam logic [7:0]  RUN_MAX    = 8'd255;
    localparam logic [1:0]  HIST_DEPTH = 2'd3;
    localparam logic [39:0] SP_MIN     = 40'd256;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_PERIOD = 3'd0;
    localparam logic [2:0] REG_MIN_STEP   = 3'd1;
    localparam logic [2:0] REG_MAX_STEP   = 3'd2;
    localparam logic [2:0] REG_EPR        = 3'd3;
    localparam logic [2:0] REG_ALPHA      = 3'd4;
    localparam logic [2:0] REG_DEADBAND   = 3'd5;
    localparam logic [2:0] REG_SLEW       = 3'd6;
    localparam logic [2:0] REG_CONFIRM    = 3'd7;

    typedef enum logic [1:0] {
        ACT_EDGE  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FILT,
        ST_MUL,
        ST_FDONE,
        ST_SCALE,
        ST_DLOAD,
        ST_DIV,
        ST_SPEED,
        ST_SLEW,
        ST_LIMIT,
        ST_OUT
    } state_t;

    function automatic logic [31:0] med3(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
        logic [31:0] x, y, z, t;
        x = a; y = b; z = c;
        if (x > y) begin t = x; x = y; y = t; end
        if (y > z) begin t = y; y = z; z = t; end
        if (x > y) begin t = x; x = y; y = t; end
        return y;
    endfunction

    function automatic logic [32:0] abs33(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return w[32] ? 33'(-w) : 33'(w);
    endfunction

    function automatic logic signed [31:0] deadband(input logic signed [31:0] r,
                                                    input logic [15:0] zdb);
        return (abs33(r) < {17'd0, zdb}) ? 32'sd0 : r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        if (v > 41'sh0007FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -41'sh00080000000) return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// File: hdl/encoder_period_rpm_estimator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// encoder_period_rpm_estimator - T-method encoder speed estimator
// Edge, query and clear events in; one RPM result (Q27.4) per event out.
// ---------------------------------------------------------------------------
//
//  channel   ports                               direction
//  -------   ---------------------------------   ---------
//  s_        action, time_us, position_count      in, valid/ready
//  m_        rpm_value, edge_accepted, dir, tout  out, valid/ready
//  cfg_      wr_en, index, wr_data                in, write only
//
// Queries, none, clears and unaccepted edges go from evaluation to output. An
// accepted edge adds the IIR filter (16 shift-add steps once the smoothed period
// is set), the RPM division and, unless the slew timer is unset or no time has
// passed, the slew-step division; a late-edge query with decay adds the RPM
// division. The 64-step restoring divider, loaded first, is shared by both. The
// input is taken only in the idle state; a result waiting on m_ready holds the
// sequencer in its output state. Synchronous active-low reset.
//
module encoder_period_rpm_estimator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [31:0]        s_time_us,
    input  logic signed [31:0] s_position_count,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_rpm_value,
    output logic               m_edge_accepted,
    output logic               m_direction_negative,
    output logic               m_timed_out,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_wr_data
);

    eprpm_pkg::state_t state_reg, state_next;

    // configuration
    logic [15:0] min_period_reg, epr_reg, alpha_reg, zdb_reg;
    logic [7:0]  min_step_reg, step_max_reg, confirm_reg;
    logic [19:0] slew_reg;

    // captured transaction
    eprpm_pkg::action_t act_reg;
    logic [31:0] t_reg, pos_reg;

    // velocity state
    logic               cap_reg, pv_reg;
    logic [31:0]        last_t_reg, last_pos_reg;
    logic [31:0]        hist_reg [3];
    logic [1:0]         fill_reg;
    logic [39:0]        sp_reg;
    logic               shown_reg, cand_reg;
    logic [7:0]         run_reg;
    logic signed [31:0] held_reg;
    logic [31:0]        slew_t_reg;

    // working registers
    logic [31:0]        per_reg;     // edge period, or time since edge for a query
    logic signed [40:0] diff_reg;
    logic signed [57:0] acc_reg;
    logic [3:0]         mcnt_reg;
    logic [52:0]        prod_reg;
    logic               kind_reg;    // 0: RPM division, 1: slew step division
    logic [47:0]        div_rem_reg, div_den_reg;
    logic [63:0]        div_num_reg, div_quo_reg;
    logic [5:0]         div_cnt_reg;
    logic signed [31:0] tgt_reg;
    logic signed [31:0] res_rpm_reg;
    logic               res_acc_reg, res_tout_reg;

    logic               m_valid_reg, m_acc_reg, m_dir_reg, m_tout_reg;
    logic signed [31:0] m_rpm_reg;

    // ---------------- event evaluation ----------------
    logic [31:0] per, dpos, mag, since, dt;
    logic        neg, step_ok;
    logic [40:0] sp_rnd;
    logic [32:0] rp, base;
    logic [34:0] limit, lim_raw;
    logic        sp_big, tmo, late;

    assign per     = t_reg - last_t_reg;
    assign since   = per;
    assign dpos    = pos_reg - last_pos_reg;
    assign neg     = dpos[31];
    assign mag     = neg ? (32'd0 - dpos) : dpos;
    assign step_ok = (per >= {16'd0, min_period_reg}) && (mag >= {24'd0, min_step_reg})
                     && (mag <= {24'd0, step_max_reg});
    assign dt      = t_reg - slew_t_reg;

    assign sp_rnd  = {1'b0, sp_reg} + 41'd128;
    assign rp      = sp_rnd[40:8];
    assign sp_big  = sp_reg > eprpm_pkg::SP_MIN;
    assign base    = sp_big ? rp : 33'(eprpm_pkg::MIN_TIMEOUT_US);
    assign lim_raw = {2'b0, base} * 35'(eprpm_pkg::TIMEOUT_PERIODS);
    always_comb begin
        limit = lim_raw;
        if (limit < 35'(eprpm_pkg::MIN_TIMEOUT_US))   limit = 35'(eprpm_pkg::MIN_TIMEOUT_US);
        if (limit > 35'(eprpm_pkg::STALL_TIMEOUT_US)) limit = 35'(eprpm_pkg::STALL_TIMEOUT_US);
    end
    assign tmo  = {3'b0, since} > limit;
    assign late = sp_big && ({1'b0, since} > rp);

    // direction hysteresis
    logic       shown_n, cand_n;
    logic [7:0] run_n;
    always_comb begin
        shown_n = shown_reg;
        cand_n  = cand_reg;
        run_n   = run_reg;
        if (!pv_reg) begin
            shown_n = neg;
            cand_n  = neg;
            run_n   = 8'd0;
        end else if (neg == shown_reg) begin
            cand_n = neg;
            run_n  = 8'd0;
        end else begin
            if (neg == cand_reg) begin
                if (run_reg < eprpm_pkg::RUN_MAX) run_n = run_reg + 8'd1;
            end else begin
                cand_n = neg;
                run_n  = 8'd1;
            end
            if (run_n >= confirm_reg) begin
                shown_n = cand_n;
                run_n   = 8'd0;
            end
        end
    end

    // ---------------- period filter ----------------
    logic [31:0]        used;
    logic [39:0]        used8;
    logic signed [41:0] inc, sp_sum;
    logic signed [57:0] acc_rnd;
    always_comb begin
        used = per_reg;
        if (eprpm_pkg::MEDIAN_ENABLE != 0 && fill_reg >= eprpm_pkg::HIST_DEPTH)
            used = eprpm_pkg::med3(hist_reg[0], hist_reg[1], hist_reg[2]);
    end
    assign used8   = {used, 8'd0};
    assign acc_rnd = acc_reg + 58'sd32768;
    assign inc     = 42'(acc_rnd >>> 16);
    assign sp_sum  = $signed({2'b0, sp_reg}) + inc;

    // ---------------- shared multiplier ----------------
    logic [32:0] mul_a;
    logic [19:0] mul_b;
    logic [52:0] mul_p;
    logic [15:0] epr_eff;
    assign epr_eff = (epr_reg == 16'd0) ? 16'd1 : epr_reg;
    always_comb begin
        if (state_reg == eprpm_pkg::ST_SLEW) begin
            mul_a = {1'b0, dt};
            mul_b = slew_reg;
        end else begin
            mul_a = (act_reg == eprpm_pkg::ACT_QUERY) ? {1'b0, per_reg} : rp;
            mul_b = {4'd0, epr_eff};
        end
    end
    assign mul_p = {20'd0, mul_a} * {33'd0, mul_b};

    // ---------------- shared divider ----------------
    logic [47:0] dl_den;
    logic [63:0] dl_num;
    logic [48:0] dv_r;
    logic        dv_ge;
    logic [48:0] dv_sub;
    always_comb begin
        if (kind_reg) begin
            dl_den = eprpm_pkg::US_PER_S;
            dl_num = {7'd0, prod_reg, 4'd0} + eprpm_pkg::US_HALF;
        end else begin
            dl_den = (prod_reg[47:0] == 48'd0) ? 48'd1 : prod_reg[47:0];
            dl_num = eprpm_pkg::RPM_NUM_Q4 + {17'd0, dl_den[47:1]};
        end
    end
    assign dv_r   = {div_rem_reg, div_num_reg[63]};
    assign dv_ge  = dv_r >= {1'b0, div_den_reg};
    assign dv_sub = dv_r - {1'b0, div_den_reg};

    // ---------------- speed from quotient ----------------
    logic signed [31:0] q_rpm, q_sel;
    logic               q_skip;
    assign q_rpm  = shown_reg ? -$signed({1'b0, div_quo_reg[30:0]})
                              :  $signed({1'b0, div_quo_reg[30:0]});
    assign q_sel  = ({2'b0, div_quo_reg[30:0]} < eprpm_pkg::abs33(held_reg)) ? q_rpm
                                                                               : held_reg;
    assign q_skip = (slew_t_reg == 32'd0) || (dt == 32'd0);

    // slew limit
    logic signed [40:0] step, delta, slewed;
    assign step  = $signed({4'd0, div_quo_reg[36:0]});
    assign delta = 41'(tgt_reg) - 41'(held_reg);
    always_comb begin
        if (delta > step)       slewed = 41'(held_reg) + step;
        else if (delta < -step) slewed = 41'(held_reg) - step;
        else                    slewed = 41'(tgt_reg);
    end

    // ---------------- sequencer: next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            eprpm_pkg::ST_IDLE:  if (s_valid) state_next = eprpm_pkg::ST_EVAL;
            eprpm_pkg::ST_EVAL: begin
                state_next = eprpm_pkg::ST_OUT;
                if (act_reg == eprpm_pkg::ACT_EDGE && cap_reg && step_ok)
                    state_next = eprpm_pkg::ST_FILT;
                if (act_reg == eprpm_pkg::ACT_QUERY && pv_reg && !tmo && late)
                    state_next = eprpm_pkg::ST_SCALE;
            end
            eprpm_pkg::ST_FILT:
                state_next = (sp_reg == 40'd0 || !pv_reg) ? eprpm_pkg::ST_SCALE
                                                          : eprpm_pkg::ST_MUL;
            eprpm_pkg::ST_MUL:   if (mcnt_reg == 4'd15) state_next = eprpm_pkg::ST_FDONE;
            eprpm_pkg::ST_FDONE: state_next = eprpm_pkg::ST_SCALE;
            eprpm_pkg::ST_SCALE: state_next = eprpm_pkg::ST_DLOAD;
            eprpm_pkg::ST_DLOAD: state_next = eprpm_pkg::ST_DIV;
            eprpm_pkg::ST_DIV:
                if (div_cnt_reg == 6'd63)
                    state_next = kind_reg ? eprpm_pkg::ST_LIMIT : eprpm_pkg::ST_SPEED;
            eprpm_pkg::ST_SPEED:
                state_next = (act_reg == eprpm_pkg::ACT_EDGE && !q_skip) ? eprpm_pkg::ST_SLEW
                                                                        : eprpm_pkg::ST_OUT;
            eprpm_pkg::ST_SLEW:  state_next = eprpm_pkg::ST_DLOAD;
            eprpm_pkg::ST_LIMIT: state_next = eprpm_pkg::ST_OUT;
            eprpm_pkg::ST_OUT:   if (!m_valid_reg || m_ready) state_next = eprpm_pkg::ST_IDLE;
            default:             state_next = eprpm_pkg::ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_ready = 1'b0;
        case (state_reg)
            eprpm_pkg::ST_IDLE: s_ready = 1'b1;
            default:            s_ready = 1'b0;
        endcase
    end

    // ---------------- control and velocity state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= eprpm_pkg::ST_IDLE;
            min_period_reg <= 16'd50;
            min_step_reg   <= 8'd2;
            step_max_reg   <= 8'd8;
            epr_reg        <= 16'd1024;
            alpha_reg      <= 16'd16384;
            zdb_reg        <= 16'd16;
            slew_reg       <= 20'd100000;
            confirm_reg    <= 8'd3;
            cap_reg        <= 1'b0;
            pv_reg         <= 1'b0;
            last_t_reg     <= 32'd0;
            last_pos_reg   <= 32'd0;
            hist_reg[0]    <= 32'd0;
            hist_reg[1]    <= 32'd0;
            hist_reg[2]    <= 32'd0;
            fill_reg       <= 2'd0;
            sp_reg         <= 40'd0;
            shown_reg      <= 1'b0;
            cand_reg       <= 1'b0;
            run_reg        <= 8'd0;
            held_reg       <= 32'sd0;
            slew_t_reg     <= 32'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    eprpm_pkg::REG_MIN_PERIOD: min_period_reg <= cfg_wr_data[15:0];
                    eprpm_pkg::REG_MIN_STEP:   min_step_reg   <= cfg_wr_data[7:0];
                    eprpm_pkg::REG_MAX_STEP:   step_max_reg   <= cfg_wr_data[7:0];
                    eprpm_pkg::REG_EPR:        epr_reg        <= cfg_wr_data[15:0];
                    eprpm_pkg::REG_ALPHA:      alpha_reg      <= cfg_wr_data[15:0];
                    eprpm_pkg::REG_DEADBAND:   zdb_reg        <= cfg_wr_data[15:0];
                    eprpm_pkg::REG_SLEW:       slew_reg       <= cfg_wr_data;
                    eprpm_pkg::REG_CONFIRM:    confirm_reg    <= cfg_wr_data[7:0];
                    default: ;
                endcase
            end

            // result register: load in the output state once free, else drain
            if (state_reg == eprpm_pkg::ST_OUT && (!m_valid_reg || m_ready))
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                eprpm_pkg::ST_EVAL: begin
                    case (act_reg)
                        eprpm_pkg::ACT_EDGE: begin
                            if (!cap_reg) begin
                                cap_reg      <= 1'b1;
                                last_t_reg   <= t_reg;
                                last_pos_reg <= pos_reg;
                            end else if (step_ok) begin
                                last_t_reg   <= t_reg;
                                last_pos_reg <= pos_reg;
                                shown_reg    <= shown_n;
                                cand_reg     <= cand_n;
                                run_reg      <= run_n;
                                if (eprpm_pkg::MEDIAN_ENABLE != 0) begin
                                    hist_reg[2] <= hist_reg[1];
                                    hist_reg[1] <= hist_reg[0];
                                    hist_reg[0] <= per;
                                    if (fill_reg < eprpm_pkg::HIST_DEPTH)
                                        fill_reg <= fill_reg + 2'd1;
                                end
                            end
                        end
                        eprpm_pkg::ACT_QUERY:
                            if (pv_reg && tmo) held_reg <= 32'sd0;
                        eprpm_pkg::ACT_CLEAR: begin
                            cap_reg      <= 1'b0;
                            pv_reg       <= 1'b0;
                            last_t_reg   <= t_reg;
                            last_pos_reg <= pos_reg;
                            hist_reg[0]  <= 32'd0;
                            hist_reg[1]  <= 32'd0;
                            hist_reg[2]  <= 32'd0;
                            fill_reg     <= 2'd0;
                            sp_reg       <= 40'd0;
                            shown_reg    <= 1'b0;
                            cand_reg     <= 1'b0;
                            run_reg      <= 8'd0;
                            held_reg     <= 32'sd0;
                            slew_t_reg   <= t_reg;
                        end
                        default: ;
                    endcase
                end
                eprpm_pkg::ST_FILT:
                    if (sp_reg == 40'd0 || !pv_reg)
                        sp_reg <= (used8 < eprpm_pkg::SP_MIN) ? eprpm_pkg::SP_MIN : used8;
                eprpm_pkg::ST_FDONE:
                    sp_reg <= (sp_sum < 42'sd256) ? eprpm_pkg::SP_MIN : sp_sum[39:0];
                eprpm_pkg::ST_SPEED:
                    if (act_reg == eprpm_pkg::ACT_EDGE && q_skip) begin
                        slew_t_reg <= t_reg;
                        held_reg   <= eprpm_pkg::deadband(q_rpm, zdb_reg);
                        pv_reg     <= 1'b1;
                    end
                eprpm_pkg::ST_LIMIT: begin
                    held_reg   <= eprpm_pkg::sat32(slewed);
                    slew_t_reg <= t_reg;
                    pv_reg     <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            eprpm_pkg::ST_IDLE:
                if (s_valid) begin
                    act_reg <= eprpm_pkg::action_t'(s_action);
                    t_reg   <= s_time_us;
                    pos_reg <= s_position_count;
                end
            eprpm_pkg::ST_EVAL: begin
                per_reg      <= per;
                res_acc_reg  <= 1'b0;
                res_tout_reg <= 1'b0;
                res_rpm_reg  <= held_reg;
                case (act_reg)
                    eprpm_pkg::ACT_QUERY:
                        if (!pv_reg || tmo) begin
                            res_rpm_reg  <= 32'sd0;
                            res_tout_reg <= pv_reg;
                        end else begin
                            res_rpm_reg <= eprpm_pkg::deadband(held_reg, zdb_reg);
                        end
                    eprpm_pkg::ACT_CLEAR: res_rpm_reg <= 32'sd0;
                    default: ;
                endcase
            end
            eprpm_pkg::ST_FILT: begin
                diff_reg <= $signed({1'b0, used8}) - $signed({1'b0, sp_reg});
                acc_reg  <= 58'sd0;
                mcnt_reg <= 4'd0;
            end
            eprpm_pkg::ST_MUL: begin
                if (alpha_reg[mcnt_reg]) acc_reg <= acc_reg + (58'(diff_reg) <<< mcnt_reg);
                mcnt_reg <= mcnt_reg + 4'd1;
            end
            eprpm_pkg::ST_SCALE: begin
                prod_reg <= mul_p;
                kind_reg <= 1'b0;
            end
            eprpm_pkg::ST_SLEW: begin
                prod_reg <= mul_p;
                kind_reg <= 1'b1;
            end
            eprpm_pkg::ST_DLOAD: begin
                div_den_reg <= dl_den;
                div_num_reg <= dl_num;
                div_rem_reg <= 48'd0;
                div_quo_reg <= 64'd0;
                div_cnt_reg <= 6'd0;
            end
            eprpm_pkg::ST_DIV: begin
                div_rem_reg <= dv_ge ? dv_sub[47:0] : dv_r[47:0];
                div_quo_reg <= {div_quo_reg[62:0], dv_ge};
                div_num_reg <= {div_num_reg[62:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end
            eprpm_pkg::ST_SPEED: begin
                tgt_reg     <= eprpm_pkg::deadband(q_rpm, zdb_reg);
                res_acc_reg <= (act_reg == eprpm_pkg::ACT_EDGE);
                if (act_reg == eprpm_pkg::ACT_EDGE)
                    res_rpm_reg <= eprpm_pkg::deadband(q_rpm, zdb_reg);
                else
                    res_rpm_reg <= eprpm_pkg::deadband(q_sel, zdb_reg);
            end
            eprpm_pkg::ST_LIMIT: res_rpm_reg <= eprpm_pkg::sat32(slewed);
            eprpm_pkg::ST_OUT:
                if (!m_valid_reg || m_ready) begin
                    m_rpm_reg  <= res_rpm_reg;
                    m_acc_reg  <= res_acc_reg;
                    m_tout_reg <= res_tout_reg;
                    m_dir_reg  <= (act_reg == eprpm_pkg::ACT_CLEAR) ? 1'b0 : shown_reg;
                end
            default: ;
        endcase
    end

    assign m_valid              = m_valid_reg;
    assign m_rpm_value          = m_rpm_reg;
    assign m_edge_accepted      = m_acc_reg;
    assign m_direction_negative = m_dir_reg;
    assign m_timed_out          = m_tout_reg;

`ifndef NO_ASSERTIONS
    a_sp_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> sp_reg >= eprpm_pkg::SP_MIN)
        else $error("smoothed period below floor while period valid");

    a_tout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_timed_out) |-> (m_rpm_value == 32'sd0 && !m_edge_accepted))
        else $error("timeout result carries speed");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rpm_value)
            && $stable(m_edge_accepted) && $stable(m_direction_negative)
            && $stable(m_timed_out)))
        else $error("result changed while stalled");

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == eprpm_pkg::ST_DIV) |-> !s_ready)
        else $error("input taken during division");
`endif

endmodule

// File: tb/tb_encoder_period_rpm_estimator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_encoder_period_rpm_estimator - self-checking bench for the RPM estimator
// Drives edge, query, clear and idle events with random idling on both
// channels, predicts every result in a scoreboard class and compares fields.
// ---------------------------------------------------------------------------
module tb_encoder_period_rpm_estimator;

    typedef struct {
        logic signed [31:0] rpm;
        logic               accepted;
        logic               dir_neg;
        logic               tout;
    } speed_result_t;

    // -----------------------------------------------------------------------
    // Speed scoreboard: own copy of registers and velocity state, a queue of
    // expected results, and field-by-field comparison.
    // -----------------------------------------------------------------------
    class speed_scoreboard_t;
        bit [15:0] min_period, epr, alpha, zdb;
        bit [7:0]  min_step, step_max, confirm;
        bit [19:0] slew_lim;

        bit        started, pvalid;
        bit [31:0] last_t, last_pos, slew_t;
        bit [31:0] hist [3];
        int        fill;
        longint unsigned sp;
        bit        shown, cand;
        int unsigned run;
        int        held;

        speed_result_t pending_q[$];
        int errors, checked, n_accepted, n_timeouts;

        function new();
            min_period = 50; min_step = 2; step_max = 8; epr = 1024;
            alpha = 16384; zdb = 16; slew_lim = 100000; confirm = 3;
            clear_state(0, 0);
        endfunction

        function void clear_state(bit [31:0] t, bit [31:0] pos);
            started = 0; pvalid = 0;
            last_t = t; last_pos = pos; slew_t = t;
            hist[0] = 0; hist[1] = 0; hist[2] = 0; fill = 0;
            sp = 0; shown = 0; cand = 0; run = 0; held = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] v);
            case (idx)
                eprpm_pkg::REG_MIN_PERIOD: min_period = v[15:0];
                eprpm_pkg::REG_MIN_STEP:   min_step   = v[7:0];
                eprpm_pkg::REG_MAX_STEP:   step_max   = v[7:0];
                eprpm_pkg::REG_EPR:        epr        = v[15:0];
                eprpm_pkg::REG_ALPHA:      alpha      = v[15:0];
                eprpm_pkg::REG_DEADBAND:   zdb        = v[15:0];
                eprpm_pkg::REG_SLEW:       slew_lim   = v;
                eprpm_pkg::REG_CONFIRM:    confirm    = v[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        function longint unsigned mag64(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // Q.4 RPM for a period in us, rounded half up, signed by direction
        function longint speed_q4(longint unsigned per, bit neg);
            longint unsigned e, d, q;
            e = (epr == 0) ? 1 : epr;
            d = per * e;
            if (d == 0) d = 1;
            q = (64'd960000000 + d / 2) / d;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        function longint dband(longint r);
            return (mag64(r) < zdb) ? 0 : r;
        endfunction

        function longint unsigned sp_rounded();
            return (sp + 128) >> 8;
        endfunction

        function int clip32(longint v);
            if (v > 64'sd2147483647) return 32'h7FFFFFFF;
            if (v < -64'sd2147483648) return 32'h80000000;
            return int'(v);
        endfunction

        function void track_direction(bit neg, bit first);
            if (first) begin
                shown = neg; cand = neg; run = 0;
                return;
            end
            if (neg == shown) begin
                cand = neg; run = 0;
                return;
            end
            if (neg == cand) begin
                if (run < 255) run++;
            end else begin
                cand = neg; run = 1;
            end
            if (run >= confirm) begin
                shown = cand; run = 0;
            end
        endfunction

        // median of three (once full) then IIR in Q32.8
        function longint unsigned smooth_period(bit [31:0] per);
            longint unsigned used, a, lo, hi;
            used = per;
            a = alpha;
            if (eprpm_pkg::MEDIAN_ENABLE != 0) begin
                hist[2] = hist[1]; hist[1] = hist[0]; hist[0] = per;
                if (fill < 3) fill++;
                if (fill >= 3) begin
                    lo = (hist[0] < hist[1]) ? hist[0] : hist[1];
                    hi = (hist[0] < hist[1]) ? hist[1] : hist[0];
                    hi = (hi < hist[2]) ? hi : hist[2];
                    used = (lo > hi) ? lo : hi;
                end
            end
            if (sp == 0 || !pvalid) sp = used << 8;
            else sp = ((65536 - a) * sp + a * (used << 8) + 32768) >> 16;
            if (sp < 256) sp = 256;
            return sp_rounded();
        endfunction

        function longint slew_to(longint target, bit [31:0] t);
            bit [31:0] dt;
            longint unsigned step;
            longint delta;
            dt = t - slew_t;
            if (slew_t == 0 || dt == 0) begin
                slew_t = t;
                return target;
            end
            step = (longint'(slew_lim) * 16 * dt + 500000) / 1000000;
            delta = target - longint'(held);
            if (delta > longint'(step)) target = longint'(held) + longint'(step);
            else if (delta < -longint'(step)) target = longint'(held) - longint'(step);
            slew_t = t;
            return target;
        endfunction

        // accepted input transaction: advance state, queue the result
        function void note_event(logic [1:0] act, bit [31:0] t, bit [31:0] pos);
            speed_result_t r;
            longint rpm, el;
            bit [31:0] per, d, mag, since;
            longint unsigned fp, base, lim;
            bit neg;
            rpm = held;
            r.accepted = 0;
            r.tout = 0;
            if (act == eprpm_pkg::ACT_EDGE) begin
                if (!started) begin
                    started = 1; last_t = t; last_pos = pos;
                end else begin
                    per = t - last_t;
                    d = pos - last_pos;
                    neg = d[31];
                    mag = neg ? -d : d;
                    if (per >= min_period && mag >= min_step && mag <= step_max) begin
                        last_t = t; last_pos = pos;
                        track_direction(neg, !pvalid);
                        fp = smooth_period(per);
                        rpm = dband(speed_q4(fp, shown));
                        held = clip32(slew_to(rpm, t));
                        pvalid = 1;
                        r.accepted = 1;
                        n_accepted++;
                    end
                end
                rpm = held;
            end else if (act == eprpm_pkg::ACT_QUERY) begin
                if (!pvalid) begin
                    rpm = 0;
                end else begin
                    since = t - last_t;
                    base = (sp > 256) ? sp_rounded() : 20000;
                    lim = base * eprpm_pkg::TIMEOUT_PERIODS;
                    if (lim < eprpm_pkg::MIN_TIMEOUT_US) lim = eprpm_pkg::MIN_TIMEOUT_US;
                    if (lim > eprpm_pkg::STALL_TIMEOUT_US) lim = eprpm_pkg::STALL_TIMEOUT_US;
                    if (since > lim) begin
                        held = 0; rpm = 0; r.tout = 1;
                        n_timeouts++;
                    end else begin
                        rpm = held;
                        // late edge: speed can be no more than one edge per elapsed time
                        if (sp > 256 && since > sp_rounded()) begin
                            el = speed_q4(since, shown);
                            if (mag64(el) < mag64(rpm)) rpm = el;
                        end
                        rpm = dband(rpm);
                    end
                end
            end else if (act == eprpm_pkg::ACT_CLEAR) begin
                clear_state(t, pos);
                rpm = 0;
            end
            r.rpm = clip32(rpm);
            r.dir_neg = (act == eprpm_pkg::ACT_CLEAR) ? 1'b0 : shown;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] rpm, logic acc, logic dneg,
                                   logic tout);
            speed_result_t e;
            checked++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: rpm %0d", $time, rpm);
                return;
            end
            e = pending_q.pop_front();
            if (rpm !== e.rpm || acc !== e.accepted || dneg !== e.dir_neg
                || tout !== e.tout) begin
                errors++;
                if (errors <= 30)
                    $display({"%0t: mismatch exp rpm %0d acc %0b dir %0b tout %0b, ",
                              "got rpm %0d acc %0b dir %0b tout %0b"},
                             $time, e.rpm, e.accepted, e.dir_neg, e.tout,
                             rpm, acc, dneg, tout);
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_action;
    logic [31:0]        s_time_us;
    logic signed [31:0] s_position_count;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_rpm_value;
    logic               m_edge_accepted;
    logic               m_direction_negative;
    logic               m_timed_out;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [19:0]        cfg_wr_data;

    speed_scoreboard_t sb;
    bit              no_idle;       // stretch with no gaps on either side
    bit [31:0]       t_now, pos_now;
    bit              spin_neg;
    int unsigned     base_period;
    int              n_events;

    encoder_period_rpm_estimator i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_action             (s_action),
        .s_time_us            (s_time_us),
        .s_position_count     (s_position_count),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_rpm_value          (m_rpm_value),
        .m_edge_accepted      (m_edge_accepted),
        .m_direction_negative (m_direction_negative),
        .m_timed_out          (m_timed_out),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wr_data          (cfg_wr_data)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one input transaction; the prediction is made at the accepting edge
    task automatic send_event(logic [1:0] act, bit [31:0] t, bit [31:0] pos);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= act;
        s_time_us        <= t;
        s_position_count <= pos;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(act, t, pos);
        n_events++;
    endtask

    // block idle: every result back, then the longest edge latency in slack
    task automatic drain();
        int guard;
        @(negedge aclk);
        s_valid <= 1'b0;
        guard = 0;
        while (sb.pending() > 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (250) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [19:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.write_reg(idx, v);
    endtask

    task automatic set_all(int mp, int mins, int maxs, int e, int a, int z, int sl,
                           int c);
        cfg_write(eprpm_pkg::REG_MIN_PERIOD, 20'(mp));
        cfg_write(eprpm_pkg::REG_MIN_STEP, 20'(mins));
        cfg_write(eprpm_pkg::REG_MAX_STEP, 20'(maxs));
        cfg_write(eprpm_pkg::REG_EPR, 20'(e));
        cfg_write(eprpm_pkg::REG_ALPHA, 20'(a));
        cfg_write(eprpm_pkg::REG_DEADBAND, 20'(z));
        cfg_write(eprpm_pkg::REG_SLEW, 20'(sl));
        cfg_write(eprpm_pkg::REG_CONFIRM, 20'(c));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic new_base();
        base_period = sb.min_period + (($urandom_range(0, 3) == 0) ?
                      $urandom_range(1, 30000) : $urandom_range(1, 2000));
    endtask

    // well-formed rotation with random content, plus queries, flips and noise
    task automatic run_spin(int n);
        int r;
        bit [31:0] step, off;
        new_base();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 39) == 0) new_base();
            if ($urandom_range(0, 59) == 0) no_idle = !no_idle;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                if (r < 8) spin_neg = !spin_neg;
                if ($urandom_range(0, 19) == 0)
                    t_now += $urandom_range(0, base_period);  // likely too soon
                else
                    t_now += base_period + $urandom_range(0, base_period / 4);
                step = (sb.min_step <= sb.step_max) ?
                       $urandom_range(sb.min_step, sb.step_max) : sb.min_step;
                pos_now = spin_neg ? pos_now - step : pos_now + step;
                send_event(eprpm_pkg::ACT_EDGE, t_now, pos_now);
            end else if (r < 85) begin
                case ($urandom_range(0, 2))
                    0: off = $urandom_range(0, base_period);
                    1: off = $urandom_range(base_period, 4 * base_period);
                    default: off = $urandom_range(0, 700000);
                endcase
                send_event(eprpm_pkg::ACT_QUERY, t_now + off, $urandom);
            end else if (r < 88) begin
                t_now += $urandom_range(0, 100);
                send_event(eprpm_pkg::ACT_CLEAR, t_now, pos_now);
            end else if (r < 90) begin
                send_event(eprpm_pkg::ACT_NONE, $urandom, $urandom);
            end else if (r < 95) begin
                send_event(eprpm_pkg::ACT_EDGE, $urandom, $urandom);
            end else begin
                // plausible count, random time
                send_event(eprpm_pkg::ACT_EDGE, $urandom,
                           pos_now + $urandom_range(0, 300) - 150);
            end
        end
    endtask

    // result channel: stalls of random length, with calm stretches
    initial begin
        int hold;
        m_ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 25)
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 3);
            end
        end
    end

    // result transactions are checked on the edge that accepts them
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_rpm_value, m_edge_accepted, m_direction_negative,
                            m_timed_out);
    end

    initial begin
        #40ms;
        $display("status: fail");
        $finish;
    end

    initial begin
        sb               = new();
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_action         = eprpm_pkg::ACT_EDGE;
        s_time_us        = '0;
        s_position_count = '0;
        cfg_wr_en        = 1'b0;
        cfg_index        = eprpm_pkg::REG_MIN_PERIOD;
        cfg_wr_data      = '0;
        no_idle          = 1'b0;
        spin_neg         = 1'b0;
        n_events         = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed checks at the reset register values
        send_event(eprpm_pkg::ACT_EDGE,  1000, 0);            // first edge only captures
        send_event(eprpm_pkg::ACT_QUERY, 1010, 0);            // no period yet
        send_event(eprpm_pkg::ACT_EDGE,  1020, 4);            // period too short
        send_event(eprpm_pkg::ACT_EDGE,  2000, 1);            // count step too small
        send_event(eprpm_pkg::ACT_EDGE,  2000, 20);           // count step too large
        send_event(eprpm_pkg::ACT_EDGE,  2000, 4);
        send_event(eprpm_pkg::ACT_EDGE,  3000, 8);
        send_event(eprpm_pkg::ACT_EDGE,  4000, 12);
        send_event(eprpm_pkg::ACT_EDGE,  5000, 16);           // median history full
        send_event(eprpm_pkg::ACT_QUERY, 5500, 0);
        send_event(eprpm_pkg::ACT_QUERY, 8000, 0);            // late edge decay
        send_event(eprpm_pkg::ACT_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_event(eprpm_pkg::ACT_EDGE,  6000, 12);           // reverse, unconfirmed
        send_event(eprpm_pkg::ACT_EDGE,  7000, 8);
        send_event(eprpm_pkg::ACT_EDGE,  8000, 4);            // reverse confirmed
        send_event(eprpm_pkg::ACT_QUERY, 100000, 0);          // stationary timeout
        send_event(eprpm_pkg::ACT_EDGE,  32'hFFFF_FF00, 0);
        send_event(eprpm_pkg::ACT_EDGE,  32'h0000_0300, 4);   // time wraps
        send_event(eprpm_pkg::ACT_EDGE,  32'h0000_1000, 32'h8000_0000);
        send_event(eprpm_pkg::ACT_EDGE,  32'h0000_2000, 32'h7FFF_FFFF);
        send_event(eprpm_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_event(eprpm_pkg::ACT_EDGE,  0, 0);
        send_event(eprpm_pkg::ACT_EDGE,  32'h7FFF_FFFF, 2);

        t_now = 32'h0010_0000;
        pos_now = 32'h0;
        run_spin(100);

        // low extremes: no limits, zero filter weight, no deadband, no slew
        drain();
        set_all(0, 0, 255, 1, 0, 0, 0, 0);
        run_spin(90);

        // high extremes
        drain();
        set_all(65535, 255, 255, 65535, 65535, 65535, 1000000, 255);
        run_spin(60);

        drain();
        set_all(100, 1, 4, 4096, 65535, 0, 1000000, 1);
        run_spin(90);

        for (int p = 0; p < 2; p++) begin
            drain();
            set_all($urandom_range(0, 500), $urandom_range(0, 3), $urandom_range(3, 40),
                    $urandom_range(1, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 200), $urandom_range(0, 1000000),
                    $urandom_range(1, 6));
            run_spin(90);
        end

        drain();
        if (sb.pending() > 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        $display("covered %0d events over 6 register settings: %0d edges accepted,",
                 n_events, sb.n_accepted);
        $display("%0d stationary timeouts, %0d results compared, %0d errors",
                 sb.n_timeouts, sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
